>>> hw/rtl/fp16_exp_range_reduction_lut_core_macros.svh
// assertion macros for the fp16 exponential core checker
// used by fp16exp_checker only; needs aclk and aresetn in scope
`ifndef FP16_EXP_RANGE_REDUCTION_LUT_CORE_MACROS_SVH
`define FP16_EXP_RANGE_REDUCTION_LUT_CORE_MACROS_SVH

// property checked while out of reset
`define FP16EXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked at every edge, reset included
`define FP16EXP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hw/rtl/fp16exp_pkg.sv
// shared constants, control struct and table helper for the fp16 exponential core
// no dependencies
package fp16exp_pkg;

    localparam int FracBitsDef   = 13;
    localparam int TableDepthDef = 1024;

    // log2(e) and ln(2) in Q60
    localparam logic [63:0] LOG2E_Q60 = 64'h171547652B82FE17;
    localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79A;

    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [15:0] HALF_NAN  = 16'h7E00;
    localparam logic [15:0] HALF_ZERO = 16'h0000;

    // per-beat control travelling down the pipe
    typedef struct packed {
        logic        valid;
        logic        last;
        logic        special;
        logic [15:0] y_spec;
    } ctrl_t;

    // round(exp(+-i*step) * 2^frac), evaluated at elaboration
    function automatic int exp_entry(int i, real step, int frac, bit negative);
        real arg;
        real v;
        arg = i * step;
        if (negative) arg = -arg;
        v = $exp(arg) * (2.0 ** frac);
        return int'($floor(v + 0.5));
    endfunction

endpackage

>>> hw/rtl/fp16exp_reduce.sv
// stages 1-2: decode, quotient q = trunc(x/ln2) and remainder r in 2^-F units
// depends on fp16exp_pkg
module fp16exp_reduce import fp16exp_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [15:0]            x,
    input  logic                   bypass,
    input  logic                   last,
    output ctrl_t                  ctrl_o,
    output logic                   r_neg_o,
    output logic [FRAC_BITS:0]     rmag_o,
    output logic                   rsat_o,
    output logic signed [7:0]      q_o
);
    localparam int F      = FRAC_BITS;
    localparam int S      = 24 - F;
    localparam int RMAG_W = F + 1;
    localparam logic [63:0] IL2 = (LOG2E_Q60 + (64'd1 << (59 - F))) >> (60 - F);
    localparam logic [63:0] L2  = (LN2_Q60 + (64'd1 << (59 - F))) >> (60 - F);

    // stage 1: magnitude scaled by 2^24 and quotient
    logic [4:0]        ef;
    logic [9:0]        frac;
    logic [40:0]       amag;
    logic [40+F+1:0]   prod1;
    ctrl_t             ctrl1_next;

    assign ef    = x[14:10];
    assign frac  = x[9:0];
    assign amag  = (ef == 5'd0) ? 41'(frac) : (41'({1'b1, frac}) << (ef - 5'd1));
    assign prod1 = amag * IL2[F:0];

    always_comb begin
        ctrl1_next.valid   = in_valid;
        ctrl1_next.last    = last;
        ctrl1_next.special = 1'b0;
        ctrl1_next.y_spec  = HALF_ZERO;
        if (bypass) begin
            ctrl1_next.special = 1'b1;
        end else if (ef == 5'h1f) begin
            ctrl1_next.special = 1'b1;
            if (frac != 10'd0)   ctrl1_next.y_spec = HALF_NAN;
            else if (!x[15])     ctrl1_next.y_spec = HALF_INF;
        end
    end

    ctrl_t       ctrl1_reg;
    logic [40:0] amag1_reg;
    logic [17:0] qm1_reg;
    logic        neg1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
        end else if (en) begin
            ctrl1_reg <= ctrl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            amag1_reg <= amag;
            qm1_reg   <= prod1[40+F+1:24+F];
            neg1_reg  <= x[15];
        end
    end

    // stage 2: remainder, floor to 2^-F, magnitude and sign
    logic [17+F:0]       p2;
    logic [41:0]         sub2;
    logic signed [42:0]  dm2;
    logic signed [42:0]  d2;
    logic signed [42:0]  r2;
    logic [42:0]         rabs2;
    logic                over2;
    logic signed [7:0]   q2;
    ctrl_t               ctrl2_next;

    assign p2    = qm1_reg * L2[F-1:0];
    assign sub2  = {p2, {S{1'b0}}};
    assign dm2   = $signed({2'b00, amag1_reg}) - $signed({1'b0, sub2});
    assign d2    = neg1_reg ? -dm2 : dm2;
    assign r2    = d2 >>> S;
    assign rabs2 = r2[42] ? 43'(-r2) : 43'(r2);
    assign over2 = qm1_reg > 18'd64;
    assign q2    = neg1_reg ? -$signed({1'b0, qm1_reg[6:0]}) : $signed({1'b0, qm1_reg[6:0]});

    // exponent range out of reach of the encoder
    always_comb begin
        ctrl2_next = ctrl1_reg;
        if (!ctrl1_reg.special && over2) begin
            ctrl2_next.special = 1'b1;
            ctrl2_next.y_spec  = neg1_reg ? HALF_ZERO : HALF_INF;
        end
    end

    ctrl_t               ctrl2_reg;
    logic                rneg2_reg;
    logic [RMAG_W-1:0]   rmag2_reg;
    logic                rsat2_reg;
    logic signed [7:0]   q2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl2_reg <= '0;
        end else if (en) begin
            ctrl2_reg <= ctrl2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rneg2_reg <= r2[42];
            rmag2_reg <= rabs2[RMAG_W-1:0];
            rsat2_reg <= |rabs2[42:RMAG_W];
            q2_reg    <= q2;
        end
    end

    assign ctrl_o  = ctrl2_reg;
    assign r_neg_o = rneg2_reg;
    assign rmag_o  = rmag2_reg;
    assign rsat_o  = rsat2_reg;
    assign q_o     = q2_reg;

endmodule

>>> hw/rtl/fp16exp_table.sv
// stages 3-4: table index from the remainder and registered table read
// depends on fp16exp_pkg
module fp16exp_table import fp16exp_pkg::*; #(
    parameter int FRAC_BITS   = FracBitsDef,
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  ctrl_t                  ctrl_i,
    input  logic                   r_neg_i,
    input  logic [FRAC_BITS:0]     rmag_i,
    input  logic                   rsat_i,
    input  logic signed [7:0]      q_i,
    output ctrl_t                  ctrl_o,
    output logic                   kzero_o,
    output logic                   neg_o,
    output logic signed [7:0]      q_o,
    output logic [FRAC_BITS+1:0]   pos_o,
    output logic [FRAC_BITS+1:0]   negv_o
);
    localparam int    F       = FRAC_BITS;
    localparam int    N       = TABLE_DEPTH;
    localparam int    TW      = F + 2;
    localparam int    RMAG_W  = F + 1;
    localparam longint ISTEP  = (20 * longint'(N) * (longint'(1) << F) + 7) / 14;
    localparam int    ISTEP_W = $clog2(ISTEP + 1);
    localparam int    PW      = RMAG_W + ISTEP_W;
    localparam int    KRW     = PW - 2 * F;
    localparam int    KW      = $clog2(N + 1);
    localparam int    AW      = $clog2(N);
    localparam real   STEP    = 0.7 / N;

    typedef logic [TW-1:0] rom_t [N];

    function automatic rom_t build_rom(bit negative);
        rom_t rom;
        for (int i = 0; i < N; i++) begin
            rom[i] = TW'(exp_entry(i + 1, STEP, F, negative));
        end
        return rom;
    endfunction

    localparam rom_t POS_ROM = build_rom(1'b0);
    localparam rom_t NEG_ROM = build_rom(1'b1);

    // stage 3: k = trunc(r * istep / 2^2F), saturated at the depth
    logic [PW-1:0]  prod3;
    logic [KRW-1:0] kraw3;
    logic [KW-1:0]  km3;

    assign prod3 = rmag_i * ISTEP[ISTEP_W-1:0];
    assign kraw3 = prod3[PW-1:2*F];
    assign km3   = (rsat_i || (kraw3 > KRW'(N))) ? KW'(N) : kraw3[KW-1:0];

    ctrl_t             ctrl3_reg;
    logic [KW-1:0]     km3_reg;
    logic              neg3_reg;
    logic signed [7:0] q3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl3_reg <= '0;
        end else if (en) begin
            ctrl3_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            km3_reg  <= km3;
            neg3_reg <= r_neg_i;
            q3_reg   <= q_i;
        end
    end

    // stage 4: table read at k-1
    logic [KW-1:0] kdec;
    logic [AW-1:0] addr4;

    assign kdec  = km3_reg - KW'(1);
    assign addr4 = kdec[AW-1:0];

    ctrl_t             ctrl4_reg;
    logic              kzero4_reg;
    logic              neg4_reg;
    logic signed [7:0] q4_reg;
    logic [TW-1:0]     pos4_reg;
    logic [TW-1:0]     negv4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl4_reg <= '0;
        end else if (en) begin
            ctrl4_reg <= ctrl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kzero4_reg <= (km3_reg == '0);
            neg4_reg   <= neg3_reg;
            q4_reg     <= q3_reg;
            pos4_reg   <= POS_ROM[addr4];
            negv4_reg  <= NEG_ROM[addr4];
        end
    end

    assign ctrl_o  = ctrl4_reg;
    assign kzero_o = kzero4_reg;
    assign neg_o   = neg4_reg;
    assign q_o     = q4_reg;
    assign pos_o   = pos4_reg;
    assign negv_o  = negv4_reg;

endmodule

>>> hw/rtl/fp16exp_pack.sv
// stages 5-6: normalize 2^q * T and round to binary16, output register
// depends on fp16exp_pkg
module fp16exp_pack import fp16exp_pkg::*; #(
    parameter int FRAC_BITS = FracBitsDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  ctrl_t                  ctrl_i,
    input  logic                   kzero_i,
    input  logic                   neg_i,
    input  logic signed [7:0]      q_i,
    input  logic [FRAC_BITS+1:0]   pos_i,
    input  logic [FRAC_BITS+1:0]   negv_i,
    output logic                   valid_o,
    output logic [15:0]            y_o,
    output logic                   last_o
);
    localparam int F   = FRAC_BITS;
    localparam int TW  = F + 2;
    localparam int PBW = $clog2(TW);

    // stage 5: pick table value, leading one, exponent and shift
    logic [TW-1:0]      t5;
    logic [PBW-1:0]     p5;
    logic signed [9:0]  be5;
    logic signed [9:0]  sh5;

    assign t5 = kzero_i ? TW'(1 << F) : (neg_i ? negv_i : pos_i);

    always_comb begin
        p5 = '0;
        for (int i = 0; i < TW; i++) begin
            if (t5[i]) p5 = PBW'(i);
        end
    end

    assign be5 = $signed(10'(p5)) + 10'(q_i) + 10'(15 - F);
    assign sh5 = (be5 >= 10'sd1) ? ($signed(10'(p5)) - 10'sd10)
                                 : (10'(F - 24) - 10'(q_i));

    ctrl_t             ctrl5_reg;
    logic [TW-1:0]     t5_reg;
    logic signed [9:0] be5_reg;
    logic signed [9:0] sh5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl5_reg <= '0;
        end else if (en) begin
            ctrl5_reg <= ctrl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t5_reg  <= t5;
            be5_reg <= be5;
            sh5_reg <= sh5;
        end
    end

    // stage 6: shift, round to nearest even, pack
    logic [9:0]        lsh;
    logic [TW+11:0]    wide;
    logic [TW:0]       one_sh;
    logic [TW:0]       mask;
    logic [TW:0]       rem;
    logic [TW:0]       half;
    logic [TW-1:0]     msh;
    logic [11:0]       m;
    logic [11:0]       mr;
    logic signed [9:0] ber;
    logic [15:0]       y6;

    assign lsh    = 10'(-sh5_reg);
    assign wide   = {12'b0, t5_reg} << lsh;
    assign one_sh = (TW+1)'(1) << sh5_reg[4:0];
    assign mask   = one_sh - (TW+1)'(1);
    assign rem    = {1'b0, t5_reg} & mask;
    assign half   = one_sh >> 1;
    assign msh    = t5_reg >> sh5_reg[4:0];

    always_comb begin
        m = '0;
        if (sh5_reg <= 10'sd0) begin
            m = wide[11:0];
        end else if (sh5_reg > 10'(TW)) begin
            m = '0;
        end else begin
            m = 12'(msh);
            if (rem > half || (rem == half && msh[0])) m = 12'(msh) + 12'd1;
        end
    end

    always_comb begin
        mr  = m;
        ber = be5_reg;
        y6  = 16'(m);
        if (be5_reg >= 10'sd1) begin
            // mantissa carry into the exponent
            if (m == 12'd2048) begin
                mr  = 12'd1024;
                ber = be5_reg + 10'sd1;
            end
            if (ber >= 10'sd31) y6 = HALF_INF;
            else                y6 = {1'b0, ber[4:0], mr[9:0]};
        end
        if (ctrl5_reg.special) y6 = ctrl5_reg.y_spec;
    end

    logic        valid_reg;
    logic        last_reg;
    logic [15:0] y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= ctrl5_reg.last;
            y_reg    <= y6;
        end
    end

    assign valid_o = valid_reg;
    assign y_o     = y_reg;
    assign last_o  = last_reg;

endmodule

>>> hw/rtl/fp16_exp_range_reduction_lut_core.sv
// fp16 exponential: one output beat per input beat, in order; throughput one beat per
// cycle when not stalled; the six register stages advance together and hold
// while the output beat waits, so s_tready follows m_tready or an empty output stage
// reset: synchronous active-low aresetn clears all stage valid bits, no beat in flight
// the exp tables are constant logic, ready from the first cycle
module fp16_exp_range_reduction_lut_core import fp16exp_pkg::*; #(
    parameter int FRAC_BITS   = FracBitsDef,
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] x
    input  logic        s_tuser,   // [0] bypass
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] y
    output logic        m_tlast
);
    logic en;

    // whole pipe moves when the output stage is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    ctrl_t                 ctrl_r;
    logic                  r_neg;
    logic [FRAC_BITS:0]    rmag;
    logic                  rsat;
    logic signed [7:0]     q_r;
    ctrl_t                 ctrl_tab;
    logic                  kzero;
    logic                  neg_tab;
    logic signed [7:0]     q_tab;
    logic [FRAC_BITS+1:0]  pos_v;
    logic [FRAC_BITS+1:0]  neg_v;

    fp16exp_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .x        (s_tdata),
        .bypass   (s_tuser),
        .last     (s_tlast),
        .ctrl_o   (ctrl_r),
        .r_neg_o  (r_neg),
        .rmag_o   (rmag),
        .rsat_o   (rsat),
        .q_o      (q_r)
    );

    fp16exp_table #(.FRAC_BITS(FRAC_BITS), .TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_i   (ctrl_r),
        .r_neg_i  (r_neg),
        .rmag_i   (rmag),
        .rsat_i   (rsat),
        .q_i      (q_r),
        .ctrl_o   (ctrl_tab),
        .kzero_o  (kzero),
        .neg_o    (neg_tab),
        .q_o      (q_tab),
        .pos_o    (pos_v),
        .negv_o   (neg_v)
    );

    fp16exp_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctrl_i   (ctrl_tab),
        .kzero_i  (kzero),
        .neg_i    (neg_tab),
        .q_i      (q_tab),
        .pos_i    (pos_v),
        .negv_i   (neg_v),
        .valid_o  (m_tvalid),
        .y_o      (m_tdata),
        .last_o   (m_tlast)
    );

endmodule

>>> hw/rtl/fp16exp_checker.sv
// port-level checks for the fp16 exponential core, bound to the top level
// depends on fp16_exp_range_reduction_lut_core_macros.svh
`include "fp16_exp_range_reduction_lut_core_macros.svh"

module fp16exp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // stalled output beat holds
    `FP16EXP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output beat changed while stalled")
    // input side opens exactly when the output stage can move
    `FP16EXP_ASSERT(a_ready_link, s_tready == (!m_tvalid || m_tready), "s_tready out of step with output stage")
    // exp never yields a negative value or a nan other than the canonical one
    `FP16EXP_ASSERT(a_result_form, m_tvalid |-> !m_tdata[15] && (m_tdata[14:10] != 5'h1f || m_tdata[9:0] == 10'h000 || m_tdata[9:0] == 10'h200), "malformed result")
    // nothing comes out straight after reset
    `FP16EXP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind fp16_exp_range_reduction_lut_core fp16exp_checker u_fp16exp_checker (.*);

>>> sim/tb_fp16_exp_range_reduction_lut_core.sv
// testbench for fp16_exp_range_reduction_lut_core: bit-exact exp predictor and stream checks
// depends on fp16exp_pkg and the core rtl
module tb_fp16_exp_range_reduction_lut_core import fp16exp_pkg::*;;

    localparam int FRAC  = FracBitsDef;
    localparam int DEPTH = TableDepthDef;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    fp16_exp_range_reduction_lut_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    typedef struct packed {
        logic [15:0] y;
        logic        last;
    } exp_beat_t;

    exp_beat_t   pending_exp[$];
    int          error_count;
    int          idle_cycles;
    bit          no_idle;
    bit          timed_out;

    longint unsigned il2_q, ln2_q, istep_q;
    int unsigned     exp_pos[DEPTH];
    int unsigned     exp_neg[DEPTH];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint unsigned q60_to_frac(longint unsigned v);
        return (v + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    endfunction

    // series for exp(+-a/b) in Q60
    function automatic longint unsigned exp_series(longint unsigned a, longint unsigned b,
                                                   bit negative);
        longint unsigned term, even_sum, odd_sum, bn;
        term = 64'd1 << 60;
        even_sum = term;
        odd_sum = 0;
        for (int n = 1; n <= 48; n++) begin
            bn = b * n;
            term = (term / bn) * a + ((term % bn) * a) / bn;
            if (term == 0) break;
            if (n % 2 == 1) odd_sum += term;
            else even_sum += term;
        end
        return negative ? even_sum - odd_sum : even_sum + odd_sum;
    endfunction

    task automatic build_exp_tables();
        longint unsigned a, b;
        il2_q = q60_to_frac(LOG2E_Q60);
        ln2_q = q60_to_frac(LN2_Q60);
        istep_q = (64'd20 * DEPTH * (64'd1 << FRAC) + 7) / 14;
        for (int i = 0; i < DEPTH; i++) begin
            a = 7 * (i + 1);
            b = 10 * DEPTH;
            exp_pos[i] = q60_to_frac(exp_series(a, b, 1'b0));
            exp_neg[i] = q60_to_frac(exp_series(a, b, 1'b1));
        end
    endtask

    // half encoding of t * 2^e2, nearest even
    function automatic logic [15:0] to_half(int unsigned t, int e2);
        int p, be, sh;
        int unsigned m, rem, hlf;
        p = 0;
        while (p < 31 && (t >> (p + 1)) != 0) p++;
        be = p + e2 + 15;
        sh = (be >= 1) ? p - 10 : -e2 - 24;
        if (sh <= 0) m = t << (-sh);
        else if (sh >= 32) m = 0;
        else begin
            rem = t & ((32'd1 << sh) - 1);
            hlf = 32'd1 << (sh - 1);
            m = t >> sh;
            if (rem > hlf || (rem == hlf && m[0])) m++;
        end
        if (be >= 1) begin
            if (m == 2048) begin
                m = 1024;
                be++;
            end
            if (be >= 31) return HALF_INF;
            return 16'((be << 10) | (m & 32'h3FF));
        end
        return 16'(m);
    endfunction

    function automatic logic [15:0] half_exp(logic [15:0] x, logic bypass);
        int unsigned     ef, frac;
        bit              neg;
        longint unsigned amag, qm, km, rmag, tval;
        longint          dm, d, r, q;
        int              s;
        s = 24 - FRAC;
        ef = x[14:10];
        frac = x[9:0];
        neg = x[15];
        if (bypass) return HALF_ZERO;
        if (ef == 31) return (frac != 0) ? HALF_NAN : (neg ? HALF_ZERO : HALF_INF);
        amag = (ef == 0) ? frac : (longint'(1024 + frac) << (ef - 1));
        qm = (amag * il2_q) >> (24 + FRAC);
        dm = longint'(amag) - longint'((qm * ln2_q) << s);
        d = neg ? -dm : dm;
        if (d >= 0) r = d >>> s;
        else r = -longint'((longint'(-d) + (64'd1 << s) - 1) >> s);
        q = neg ? -longint'(qm) : longint'(qm);
        rmag = (r >= 0) ? r : -r;
        km = (rmag * istep_q) >> (2 * FRAC);
        if (km > DEPTH) km = DEPTH;
        if (km == 0) tval = 64'd1 << FRAC;
        else tval = (r > 0) ? exp_pos[km - 1] : exp_neg[km - 1];
        if (q > 64) return HALF_INF;
        if (q < -64) return HALF_ZERO;
        return to_half(32'(tval), int'(q) - FRAC);
    endfunction

    // send one beat, with an optional random gap first
    task automatic send_beat(logic [15:0] x, logic bypass, logic last);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= bypass;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_exp.push_back('{y: half_exp(x, bypass), last: last});
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (pending_exp.size() != 0) @(posedge aclk);
    endtask

    task automatic test_special_values();
        logic [15:0] edge_vals[16];
        edge_vals = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFD01,
                      16'h7BFF, 16'hFBFF, 16'h0001, 16'h8001, 16'h3C00, 16'hBC00,
                      16'h498C, 16'hCC55, 16'hC8E0, 16'h03FF};
        foreach (edge_vals[i]) send_beat(edge_vals[i], 1'b0, i[0]);
        send_beat(16'h3C00, 1'b1, 1'b1);
        send_beat(16'h7E00, 1'b1, 1'b0);
        send_beat(16'hFFFF, 1'b1, 1'b1);
        send_beat(16'h4000, 1'b0, 1'b1);
    endtask

    // pause until every result is back, then send two more beats
    task automatic test_drain_pause();
        wait_drained();
        send_beat(16'h3800, 1'b0, 1'b0);
        send_beat(16'hB800, 1'b0, 1'b1);
    endtask

    // mostly in-range values where the table matters, some full-range noise
    task automatic test_random_values(int count);
        logic [15:0] x;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) x = 16'($urandom);
            else x = {1'($urandom), 5'($urandom_range(0, 18)), 10'($urandom)};
            send_beat(x, $urandom_range(0, 15) == 0, 1'($urandom));
        end
    endtask

    task automatic test_streaming_tail(int count);
        no_idle = 1'b1;
        test_random_values(count);
        end_burst();
    endtask

    // result checker
    always @(posedge aclk) begin
        exp_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_exp.size() == 0) begin
                $display("%0t unexpected result y=%h last=%b", $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = pending_exp.pop_front();
                if (m_tdata !== want.y) begin
                    $display("%0t y mismatch: expected %h actual %h", $time, want.y, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t last mismatch: expected %b actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 16);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (s_tvalid || pending_exp.size() != 0) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end

    initial begin
        wait (timed_out);
        $display("tb_fp16_exp_range_reduction_lut_core: errors");
        $finish;
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        timed_out = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        build_exp_tables();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_values();
        test_drain_pause();
        test_random_values(1100);
        test_streaming_tail(300);
        wait_drained();
        repeat (12) @(posedge aclk);
        if (error_count == 0) $display("tb_fp16_exp_range_reduction_lut_core: clean");
        else $display("tb_fp16_exp_range_reduction_lut_core: errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/fp16exp_pkg.sv
hw/rtl/fp16exp_reduce.sv
hw/rtl/fp16exp_table.sv
hw/rtl/fp16exp_pack.sv
hw/rtl/fp16_exp_range_reduction_lut_core.sv
hw/rtl/fp16exp_checker.sv
sim/tb_fp16_exp_range_reduction_lut_core.sv
